>>> hw/rtl/mono_note_priority_handler_unit_defines.svh
// ---------------------------------------------------------------------------
// mono note priority handler assertion macros
// shared concurrent assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef MONO_NOTE_PRIORITY_HANDLER_UNIT_DEFINES_SVH
`define MONO_NOTE_PRIORITY_HANDLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MNPH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mnph checker: implication failed");

// next-cycle implication, disabled during reset
`define MNPH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mnph checker: next-cycle implication failed");

`endif

>>> hw/rtl/mnph_pkg.sv
// ---------------------------------------------------------------------------
// mnph_pkg
// types, codes and sizes shared by the mono note priority handler
// ---------------------------------------------------------------------------
package mnph_pkg;

    // note table geometry
    localparam int NOTE_COUNT   = 128;
    localparam int NOTE_W       = $clog2(NOTE_COUNT);
    localparam int VEL_W        = 7;
    localparam int CHANNEL_W    = 4;
    localparam int TS_W         = 16;
    localparam int RAW_W        = 24;
    localparam int MAX_HELD     = 64;
    localparam int COUNT_W      = $clog2(MAX_HELD + 1);

    // lowest-note search: one group of lanes per cycle
    localparam int SCAN_LANES   = 16;
    localparam int GROUP_COUNT  = NOTE_COUNT / SCAN_LANES;
    localparam int GROUP_IDX_W  = $clog2(GROUP_COUNT);
    localparam int LANE_IDX_W   = $clog2(SCAN_LANES);

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_OTHER    = 2'd2,
        OP_SET_MODE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NOTE_OFF = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_PASS     = 2'd2
    } kind_t;

    // which result the output register is loaded with
    typedef enum logic [2:0] {
        RES_PASS,
        RES_POLY,
        RES_CUR_OFF,
        RES_MONO_ON,
        RES_REL_OFF,
        RES_RETRIG,
        RES_SWEEP_OFF
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PASS,
        S_POLY,
        S_MON_OFF,
        S_MON_ON,
        S_REL_SCAN,
        S_REL_OFF,
        S_REL_ON,
        S_SW_SCAN,
        S_SW_EMIT
    } state_t;

    typedef struct packed {
        op_t                  operation;
        logic [CHANNEL_W-1:0] channel;
        logic [NOTE_W-1:0]    note;
        logic [VEL_W-1:0]     velocity;
        logic [TS_W-1:0]      timestamp;
        logic [RAW_W-1:0]     raw_message;
        logic                 mono_request;
    } in_item_t;

    typedef struct packed {
        kind_t                kind;
        logic [CHANNEL_W-1:0] channel;
        logic [NOTE_W-1:0]    note;
        logic [VEL_W-1:0]     velocity;
        logic [TS_W-1:0]      timestamp;
        logic [RAW_W-1:0]     raw;
        logic                 last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     set_mode;
        logic     store_on;
        logic     store_off;
        logic     scan_start;
        logic     scan_step;
        logic     sweep_clear;
        logic     set_current_found;
        logic     emit;
        res_sel_t res_sel;
        logic     last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic mono_request;
        logic mono_mode;
        logic current_valid;
        logic count_zero;
        logic count_one;
        logic out_free;
        logic scan_hit;
        logic scan_end;
        logic found;
    } dp_status_t;

endpackage

>>> hw/rtl/mnph_if.sv
// ---------------------------------------------------------------------------
// mnph channel interfaces
// valid/ready channels for incoming midi events and emitted results
// ---------------------------------------------------------------------------
interface mnph_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [mnph_pkg::CHANNEL_W-1:0]  channel;
    logic [mnph_pkg::NOTE_W-1:0]     note;
    logic [mnph_pkg::VEL_W-1:0]      velocity;
    logic [mnph_pkg::TS_W-1:0]       timestamp;
    logic [mnph_pkg::RAW_W-1:0]      raw_message;
    logic                            mono_request;

    modport source (
        output valid, operation, channel, note, velocity, timestamp, raw_message,
               mono_request,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, note, velocity, timestamp, raw_message,
               mono_request,
        output ready
    );
endinterface

interface mnph_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [mnph_pkg::CHANNEL_W-1:0]  out_channel;
    logic [mnph_pkg::NOTE_W-1:0]     out_note;
    logic [mnph_pkg::VEL_W-1:0]      out_velocity;
    logic [mnph_pkg::TS_W-1:0]       out_timestamp;
    logic [mnph_pkg::RAW_W-1:0]      out_raw;
    logic                            last;

    modport source (
        output valid, kind, out_channel, out_note, out_velocity, out_timestamp, out_raw,
               last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_channel, out_note, out_velocity, out_timestamp, out_raw,
               last,
        output ready
    );
endinterface

>>> hw/rtl/mnph_ram.sv
// ---------------------------------------------------------------------------
// mnph_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module mnph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mnph_datapath.sv
// ---------------------------------------------------------------------------
// mnph_datapath
// held-note table, current note, mode, lowest-note search and result register
// ---------------------------------------------------------------------------
module mnph_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mnph_pkg::in_item_t   in_item,
    input  mnph_pkg::ctrl_cmd_t  cmd,
    input  logic                 out_ready,
    output mnph_pkg::dp_status_t status,
    output mnph_pkg::out_item_t  out_item,
    output logic                 out_valid
);

    mnph_pkg::in_item_t                    item_reg;
    logic [mnph_pkg::NOTE_COUNT-1:0]       held_reg, held_next;
    logic [mnph_pkg::COUNT_W-1:0]          count_reg, count_next;
    logic [mnph_pkg::NOTE_W-1:0]           cur_note_reg, cur_note_next;
    logic                                  cur_valid_reg, cur_valid_next;
    logic                                  mono_reg, mono_next;
    logic [mnph_pkg::GROUP_IDX_W-1:0]      group_reg, group_next;
    logic                                  found_reg, found_next;
    logic [mnph_pkg::NOTE_W-1:0]           found_note_reg, found_note_next;
    logic                                  out_valid_reg;
    mnph_pkg::out_item_t                   out_item_reg;
    mnph_pkg::out_item_t                   res;

    logic [mnph_pkg::SCAN_LANES-1:0]       group_bits;
    logic                                  lane_hit;
    logic [mnph_pkg::LANE_IDX_W-1:0]       lane_idx;
    logic [mnph_pkg::NOTE_W-1:0]           scan_note;
    logic                                  scan_end;
    logic                                  note_held;
    logic                                  table_room;
    logic                                  ram_we;
    logic [mnph_pkg::VEL_W-1:0]            ram_rdata;
    logic                                  out_free;

    // input item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // lowest held note within the current group of lanes
    assign group_bits = held_reg[{group_reg, mnph_pkg::LANE_IDX_W'(0)} +: mnph_pkg::SCAN_LANES];

    always_comb
    begin
        lane_hit = 1'b0;
        lane_idx = '0;
        for (int i = mnph_pkg::SCAN_LANES - 1; i >= 0; i--)
        begin
            if (group_bits[i])
            begin
                lane_hit = 1'b1;
                lane_idx = mnph_pkg::LANE_IDX_W'(i);
            end
        end
    end

    assign scan_note = {group_reg, lane_idx};
    assign scan_end  = (group_reg == mnph_pkg::GROUP_IDX_W'(mnph_pkg::GROUP_COUNT - 1));

    // search cursor and found note
    always_comb
    begin
        group_next      = group_reg;
        found_next      = found_reg;
        found_note_next = found_note_reg;
        if (cmd.scan_start)
        begin
            group_next = '0;
            found_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (lane_hit)
            begin
                found_next      = 1'b1;
                found_note_next = scan_note;
            end
            else if (!scan_end)
            begin
                group_next = group_reg + mnph_pkg::GROUP_IDX_W'(1);
            end
        end
    end

    // held-note table and sounding-note updates
    assign note_held  = held_reg[item_reg.note];
    assign table_room = (count_reg < mnph_pkg::COUNT_W'(mnph_pkg::MAX_HELD));
    assign ram_we     = cmd.store_on && (item_reg.velocity != '0) && (note_held || table_room);

    always_comb
    begin
        held_next      = held_reg;
        count_next     = count_reg;
        cur_note_next  = cur_note_reg;
        cur_valid_next = cur_valid_reg;
        mono_next      = mono_reg;
        if (cmd.store_on)
        begin
            cur_note_next  = item_reg.note;
            cur_valid_next = 1'b1;
            if (item_reg.velocity == '0)
            begin
                if (note_held)
                begin
                    held_next[item_reg.note] = 1'b0;
                    count_next = count_reg - mnph_pkg::COUNT_W'(1);
                end
            end
            else if (!note_held && table_room)
            begin
                held_next[item_reg.note] = 1'b1;
                count_next = count_reg + mnph_pkg::COUNT_W'(1);
            end
        end
        if (cmd.store_off)
        begin
            cur_valid_next = 1'b0;
            if (note_held)
            begin
                held_next[item_reg.note] = 1'b0;
                count_next = count_reg - mnph_pkg::COUNT_W'(1);
            end
        end
        if (cmd.sweep_clear)
        begin
            held_next[found_note_reg] = 1'b0;
            count_next = count_reg - mnph_pkg::COUNT_W'(1);
        end
        if (cmd.set_mode)
        begin
            mono_next = item_reg.mono_request;
            if (item_reg.mono_request)
            begin
                cur_valid_next = 1'b0;
                cur_note_next  = '0;
            end
        end
        if (cmd.set_current_found)
        begin
            cur_note_next  = found_note_reg;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            count_reg     <= '0;
            cur_note_reg  <= '0;
            cur_valid_reg <= 1'b0;
            mono_reg      <= 1'b0;
            group_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            count_reg     <= count_next;
            cur_note_reg  <= cur_note_next;
            cur_valid_reg <= cur_valid_next;
            mono_reg      <= mono_next;
            group_reg     <= group_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_note_reg <= found_note_next;
    end

    // velocity store, written for held notes and read at the search position
    mnph_ram #(
        .WIDTH (mnph_pkg::VEL_W),
        .DEPTH (mnph_pkg::NOTE_COUNT)
    ) u_vel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.note),
        .wdata (item_reg.velocity),
        .re    (cmd.scan_step),
        .raddr (scan_note),
        .rdata (ram_rdata)
    );

    // result selection
    always_comb
    begin
        res           = '0;
        res.kind      = mnph_pkg::KIND_NOTE_OFF;
        res.timestamp = item_reg.timestamp;
        res.last      = cmd.last;
        case (cmd.res_sel)
            mnph_pkg::RES_PASS:
            begin
                res.kind    = mnph_pkg::KIND_PASS;
                res.channel = item_reg.channel;
                res.raw     = item_reg.raw_message;
            end
            mnph_pkg::RES_POLY:
            begin
                res.kind     = (item_reg.operation == mnph_pkg::OP_NOTE_ON) ?
                               mnph_pkg::KIND_NOTE_ON : mnph_pkg::KIND_NOTE_OFF;
                res.channel  = item_reg.channel;
                res.note     = item_reg.note;
                res.velocity = item_reg.velocity;
            end
            mnph_pkg::RES_CUR_OFF:
            begin
                res.note = cur_note_reg;
            end
            mnph_pkg::RES_MONO_ON:
            begin
                res.kind     = mnph_pkg::KIND_NOTE_ON;
                res.note     = item_reg.note;
                res.velocity = item_reg.velocity;
            end
            mnph_pkg::RES_REL_OFF:
            begin
                res.note = item_reg.note;
            end
            mnph_pkg::RES_RETRIG:
            begin
                res.kind     = mnph_pkg::KIND_NOTE_ON;
                res.note     = found_note_reg;
                res.velocity = ram_rdata;
            end
            mnph_pkg::RES_SWEEP_OFF:
            begin
                res.note      = found_note_reg;
                res.timestamp = '0;
            end
            default:
            begin
                res.note = item_reg.note;
            end
        endcase
    end

    // output register: the next result loads as the current one leaves
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg <= res;
        end
    end

    assign out_item  = out_item_reg;
    assign out_valid = out_valid_reg;

    // status back to the controller
    assign status.op            = item_reg.operation;
    assign status.mono_request  = item_reg.mono_request;
    assign status.mono_mode     = mono_reg;
    assign status.current_valid = cur_valid_reg;
    assign status.count_zero    = (count_reg == '0);
    assign status.count_one     = (count_reg == mnph_pkg::COUNT_W'(1));
    assign status.out_free      = out_free;
    assign status.scan_hit      = lane_hit;
    assign status.scan_end      = scan_end;
    assign status.found         = found_reg;

endmodule

>>> hw/rtl/mnph_ctrl.sv
// ---------------------------------------------------------------------------
// mnph_ctrl
// event sequencer: decodes each event and steps the datapath through its results
// ---------------------------------------------------------------------------
module mnph_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mnph_pkg::dp_status_t status,
    output logic                 in_ready,
    output mnph_pkg::ctrl_cmd_t  cmd
);

    mnph_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mnph_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            mnph_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mnph_pkg::S_DECODE;
                end
            end
            mnph_pkg::S_DECODE:
            begin
                unique case (status.op) inside
                    mnph_pkg::OP_SET_MODE:
                    begin
                        if (status.mono_request && !status.mono_mode && !status.count_zero)
                        begin
                            state_next = mnph_pkg::S_SW_SCAN;
                        end
                        else
                        begin
                            state_next = mnph_pkg::S_IDLE;
                        end
                    end
                    mnph_pkg::OP_OTHER:
                    begin
                        state_next = mnph_pkg::S_PASS;
                    end
                    mnph_pkg::OP_NOTE_ON, mnph_pkg::OP_NOTE_OFF:
                    begin
                        if (!status.mono_mode)
                        begin
                            state_next = mnph_pkg::S_POLY;
                        end
                        else if (status.op == mnph_pkg::OP_NOTE_ON)
                        begin
                            state_next = status.current_valid ? mnph_pkg::S_MON_OFF :
                                                                mnph_pkg::S_MON_ON;
                        end
                        else
                        begin
                            state_next = mnph_pkg::S_REL_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = mnph_pkg::S_IDLE;
                    end
                endcase
            end
            mnph_pkg::S_PASS, mnph_pkg::S_POLY, mnph_pkg::S_MON_ON, mnph_pkg::S_REL_ON:
            begin
                if (status.out_free)
                begin
                    state_next = mnph_pkg::S_IDLE;
                end
            end
            mnph_pkg::S_MON_OFF:
            begin
                if (status.out_free)
                begin
                    state_next = mnph_pkg::S_MON_ON;
                end
            end
            mnph_pkg::S_REL_SCAN:
            begin
                if (status.scan_hit || status.scan_end)
                begin
                    state_next = mnph_pkg::S_REL_OFF;
                end
            end
            mnph_pkg::S_REL_OFF:
            begin
                if (status.out_free)
                begin
                    state_next = status.found ? mnph_pkg::S_REL_ON : mnph_pkg::S_IDLE;
                end
            end
            mnph_pkg::S_SW_SCAN:
            begin
                if (status.scan_hit)
                begin
                    state_next = mnph_pkg::S_SW_EMIT;
                end
                else if (status.scan_end)
                begin
                    state_next = mnph_pkg::S_IDLE;
                end
            end
            mnph_pkg::S_SW_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.count_one ? mnph_pkg::S_IDLE : mnph_pkg::S_SW_SCAN;
                end
            end
            default:
            begin
                state_next = mnph_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.res_sel = mnph_pkg::RES_PASS;
        unique case (state_reg) inside
            mnph_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mnph_pkg::S_DECODE:
            begin
                if (status.op == mnph_pkg::OP_SET_MODE)
                begin
                    cmd.set_mode   = (status.mono_request != status.mono_mode);
                    cmd.scan_start = status.mono_request && !status.mono_mode;
                end
                else if (status.mono_mode && (status.op == mnph_pkg::OP_NOTE_OFF))
                begin
                    cmd.store_off  = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            end
            mnph_pkg::S_PASS:
            begin
                cmd.emit    = status.out_free;
                cmd.res_sel = mnph_pkg::RES_PASS;
                cmd.last    = 1'b1;
            end
            mnph_pkg::S_POLY:
            begin
                cmd.emit      = status.out_free;
                cmd.res_sel   = mnph_pkg::RES_POLY;
                cmd.last      = 1'b1;
                cmd.store_on  = status.out_free && (status.op == mnph_pkg::OP_NOTE_ON);
                cmd.store_off = status.out_free && (status.op == mnph_pkg::OP_NOTE_OFF);
            end
            mnph_pkg::S_MON_OFF:
            begin
                cmd.emit    = status.out_free;
                cmd.res_sel = mnph_pkg::RES_CUR_OFF;
            end
            mnph_pkg::S_MON_ON:
            begin
                cmd.emit     = status.out_free;
                cmd.res_sel  = mnph_pkg::RES_MONO_ON;
                cmd.last     = 1'b1;
                cmd.store_on = status.out_free;
            end
            mnph_pkg::S_REL_SCAN, mnph_pkg::S_SW_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            mnph_pkg::S_REL_OFF:
            begin
                cmd.emit    = status.out_free;
                cmd.res_sel = mnph_pkg::RES_REL_OFF;
                cmd.last    = !status.found;
            end
            mnph_pkg::S_REL_ON:
            begin
                cmd.emit              = status.out_free;
                cmd.res_sel           = mnph_pkg::RES_RETRIG;
                cmd.last              = 1'b1;
                cmd.set_current_found = status.out_free;
            end
            mnph_pkg::S_SW_EMIT:
            begin
                cmd.emit        = status.out_free;
                cmd.res_sel     = mnph_pkg::RES_SWEEP_OFF;
                cmd.last        = status.count_one;
                cmd.sweep_clear = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mono_note_priority_handler_unit.sv
// ---------------------------------------------------------------------------
// mono_note_priority_handler_unit
// lowest-note-priority mono handler for midi events, with poly passthrough
// midi (sink): one event per transfer; ready is high only while the sequencer idles,
//   so events are taken one at a time, and the next one is taken while a result waits
// result (source): one transfer per emitted event, last marks an event's final result
// other events and poly notes give one result; mono note-on: an off for the sounding
//   note, if any, then the on; mono note-off: the lowest-note search (one 16-note
//   group of the held table per cycle), the off, then the retrigger if a note is found
// switch to mono: one search and one note-off per held note, ascending note order
// receiver stall: the single output register holds its result and the sequencer
//   waits in place; nothing is dropped
// reset: held table, mode (poly) and sounding note clear at once, no sweep
// ---------------------------------------------------------------------------
module mono_note_priority_handler_unit (
    input  logic    clk,
    input  logic    rst_n,
    mnph_in_if.sink  midi,
    mnph_out_if.source result
);

    mnph_pkg::in_item_t   in_item;
    mnph_pkg::out_item_t  out_item;
    mnph_pkg::ctrl_cmd_t  cmd;
    mnph_pkg::dp_status_t status;
    logic                 in_ready;
    logic                 out_valid;

    // pack the incoming event
    assign in_item.operation    = mnph_pkg::op_t'(midi.operation);
    assign in_item.channel      = midi.channel;
    assign in_item.note         = midi.note;
    assign in_item.velocity     = midi.velocity;
    assign in_item.timestamp    = midi.timestamp;
    assign in_item.raw_message  = midi.raw_message;
    assign in_item.mono_request = midi.mono_request;
    assign midi.ready           = in_ready;

    mnph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (midi.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mnph_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .out_ready (result.ready),
        .status    (status),
        .out_item  (out_item),
        .out_valid (out_valid)
    );

    // unpack the result
    assign result.valid         = out_valid;
    assign result.kind          = out_item.kind;
    assign result.out_channel   = out_item.channel;
    assign result.out_note      = out_item.note;
    assign result.out_velocity  = out_item.velocity;
    assign result.out_timestamp = out_item.timestamp;
    assign result.out_raw       = out_item.raw;
    assign result.last          = out_item.last;

endmodule

>>> hw/rtl/mnph_checker.sv
// ---------------------------------------------------------------------------
// mnph_checker
// port-level checks on the mono note priority handler, bound to the top level
// ---------------------------------------------------------------------------
`include "mono_note_priority_handler_unit_defines.svh"

module mnph_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    kind,
    input logic [mnph_pkg::NOTE_W-1:0]   out_note,
    input logic [mnph_pkg::VEL_W-1:0]    out_velocity,
    input logic [mnph_pkg::RAW_W-1:0]    out_raw,
    input logic                          last
);

    logic pass_out;
    logic note_out;
    logic pass_shape_ok;

    // result classes seen on the port
    assign pass_out      = out_valid && (kind == mnph_pkg::KIND_PASS);
    assign note_out      = out_valid && (kind != mnph_pkg::KIND_PASS);
    assign pass_shape_ok = (out_note == '0) && (out_velocity == '0) && last;

    // a transfer in starts a sequence, so the next cycle takes nothing
    `MNPH_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a stalled result stays offered
    `MNPH_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)

    // passed-through events are single results without note data
    `MNPH_ASSERT_IMP(a_pass_shape, clk, rst_n, pass_out, pass_shape_ok)

    // note events never carry raw bytes
    `MNPH_ASSERT_IMP(a_note_raw_clear, clk, rst_n, note_out, out_raw == '0)

endmodule

bind mono_note_priority_handler_unit mnph_checker u_mnph_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (midi.valid),
    .in_ready     (midi.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .kind         (result.kind),
    .out_note     (result.out_note),
    .out_velocity (result.out_velocity),
    .out_raw      (result.out_raw),
    .last         (result.last)
);
